// File: src/kmp_pkg.sv
package kmp_pkg;

	localparam int MAX_PATTERN_DEF = 1024;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		FUNC_PATTERN = 2'd0,
		FUNC_TEXT    = 2'd1,
		FUNC_FINISH  = 2'd2
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  symbol;
		logic        first;
	} kmp_req_t;

	typedef struct packed {
		logic [15:0] match_count;
		logic        pattern_overflow;
	} kmp_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_COMPARE
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic fallback;
	} scan_cmd_t;

	typedef struct packed {
		logic done;
	} scan_sts_t;

endpackage

// File: src/kmp_ram.sv
module kmp_ram import kmp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MAX_PATTERN_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/kmp_scan.sv
module kmp_scan import kmp_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int AW = $clog2(MAX_PATTERN),
	localparam int LW = AW + 1
) (
	input  logic          clk,
	input  scan_cmd_t     cmd,
	input  logic [LW-1:0] start_j,
	input  logic [7:0]    sym,
	input  logic [7:0]    pat_rdata,
	input  logic [AW-1:0] pre_rdata,
	output logic [AW-1:0] pat_raddr,
	output logic [AW-1:0] pre_raddr,
	output scan_sts_t     sts,
	output logic [LW-1:0] result
);

	logic [LW-1:0] j_q;
	logic [7:0]    sym_q;
	logic [LW-1:0] j_prev;
	logic          hit;

	// hold position and symbol; fall back through the prefix table on mismatch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			j_q   <= start_j;
			sym_q <= sym;
		end else if (cmd.fallback) begin
			j_q <= LW'(pre_rdata);
		end
	end

	assign j_prev    = j_q - LW'(1);
	assign pat_raddr = j_q[AW-1:0];
	assign pre_raddr = j_prev[AW-1:0];

	assign hit      = (pat_rdata == sym_q);
	assign sts.done = hit || (j_q == '0);
	assign result   = j_q + LW'(hit);

endmodule

// File: src/kmp_seq.sv
module kmp_seq import kmp_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int AW = $clog2(MAX_PATTERN),
	localparam int LW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kmp_req_t      req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kmp_rsp_t      rsp,
	output scan_cmd_t     scan_cmd,
	output logic [LW-1:0] scan_start,
	output logic [7:0]    scan_sym,
	input  scan_sts_t     scan_sts,
	input  logic [LW-1:0] scan_result,
	output logic          pat_we,
	output logic [AW-1:0] pat_waddr,
	output logic [7:0]    pat_wdata,
	output logic          pre_we,
	output logic [AW-1:0] pre_waddr,
	output logic [AW-1:0] pre_wdata
);

	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

	seq_state_t    state_q, state_d;
	logic [LW-1:0] len_q;
	logic [AW-1:0] build_q;
	logic [LW-1:0] mpos_q;
	logic [15:0]   total_q;
	logic          ovf_q;
	logic          build_mode_q;
	logic          rsp_valid_q;
	kmp_rsp_t      rsp_q;

	logic          accept;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] text_start;

	assign req_ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept     = req_valid && req_ready;
	assign len_eff    = req.first ? '0 : len_q;
	assign text_start = (mpos_q >= len_q) ? '0 : mpos_q;

	assign scan_sym   = req.symbol;
	assign scan_start = (req.func == FUNC_TEXT) ? text_start : LW'(build_q);
	assign pat_waddr  = len_eff[AW-1:0];
	assign pat_wdata  = req.symbol;
	assign pre_waddr  = (state_q == ST_IDLE) ? '0 : len_q[AW-1:0];
	assign pre_wdata  = (state_q == ST_IDLE) ? '0 : scan_result[AW-1:0];

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d           = state_q;
		scan_cmd.load     = 1'b0;
		scan_cmd.fallback = 1'b0;
		pat_we            = 1'b0;
		pre_we            = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_PATTERN: begin
							if (len_eff < MAX_LEN) begin
								pat_we = 1'b1;
								if (len_eff != '0) begin
									scan_cmd.load = 1'b1;
									state_d       = ST_FETCH;
								end else begin
									pre_we = 1'b1;
								end
							end
						end
						FUNC_TEXT: begin
							if (len_q != '0) begin
								scan_cmd.load = 1'b1;
								state_d       = ST_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				state_d = ST_COMPARE;
			end
			ST_COMPARE: begin
				if (scan_sts.done) begin
					pre_we  = build_mode_q;
					state_d = ST_IDLE;
				end else begin
					scan_cmd.fallback = 1'b1;
					state_d           = ST_FETCH;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			build_q      <= '0;
			mpos_q       <= '0;
			total_q      <= '0;
			ovf_q        <= 1'b0;
			build_mode_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				case (req.func)
					FUNC_PATTERN: begin
						if (req.first) begin
							len_q   <= '0;
							build_q <= '0;
							mpos_q  <= '0;
							ovf_q   <= 1'b0;
						end
						if (len_eff >= MAX_LEN) begin
							ovf_q <= 1'b1;
						end else if (len_eff == '0) begin
							len_q   <= LW'(1);
							build_q <= '0;
						end else begin
							build_mode_q <= 1'b1;
						end
					end
					FUNC_TEXT: begin
						build_mode_q <= 1'b0;
					end
					FUNC_FINISH: begin
						total_q     <= '0;
						mpos_q      <= '0;
						rsp_valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (state_q == ST_COMPARE && scan_sts.done) begin
				if (build_mode_q) begin
					len_q   <= len_q + LW'(1);
					build_q <= scan_result[AW-1:0];
				end else if (scan_result == len_q) begin
					if (total_q != COUNT_MAX) begin
						total_q <= total_q + 16'd1;
					end
					mpos_q <= '0;
				end else begin
					mpos_q <= scan_result;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_FINISH) begin
			rsp_q.match_count      <= total_q;
			rsp_q.pattern_overflow <= ovf_q;
		end
	end

endmodule

// File: src/kmp_nonoverlap_match_counter.sv
// Non-overlapping pattern match counter.
// Requests arrive on req (req_valid/req_ready), one byte each: pattern
// bytes (first = 1 opens a new pattern), text bytes, or a finish request.
// Each pattern byte is stored and its prefix-table entry is built on the
// spot; each text byte advances the match position. A finish request puts
// the match count and the pattern overflow flag on rsp (rsp_valid/
// rsp_ready) and clears the count and the match position.
// A pattern or text byte that needs a scan is read from the pattern and
// prefix memories and compared in the shared unit, and the read and the
// compare are repeated once for each prefix-table fallback for that byte.
// A first or dropped pattern byte, a text byte with no pattern, and a
// finish request need no scan.
// A finish request shows its response on the cycle after it is accepted.
// Pattern bytes beyond MAX_PATTERN are dropped and set the overflow flag.
// req_ready is low while a byte is in work, and also while a response is
// waiting and rsp_ready is low, so a stalled receiver holds off requests.
// Reset clears the pattern length, match position, count and flag; the
// memories need no clearing, only written entries are ever read.
module kmp_nonoverlap_match_counter import kmp_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int AW = $clog2(MAX_PATTERN),
	localparam int LW = AW + 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  kmp_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output kmp_rsp_t rsp
);

	scan_cmd_t     scan_cmd;
	scan_sts_t     scan_sts;
	logic [LW-1:0] scan_start;
	logic [7:0]    scan_sym;
	logic [LW-1:0] scan_result;
	logic          pat_we;
	logic [AW-1:0] pat_waddr;
	logic [7:0]    pat_wdata;
	logic [AW-1:0] pat_raddr;
	logic [7:0]    pat_rdata;
	logic          pre_we;
	logic [AW-1:0] pre_waddr;
	logic [AW-1:0] pre_wdata;
	logic [AW-1:0] pre_raddr;
	logic [AW-1:0] pre_rdata;

	kmp_seq #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.scan_cmd   (scan_cmd),
		.scan_start (scan_start),
		.scan_sym   (scan_sym),
		.scan_sts   (scan_sts),
		.scan_result(scan_result),
		.pat_we     (pat_we),
		.pat_waddr  (pat_waddr),
		.pat_wdata  (pat_wdata),
		.pre_we     (pre_we),
		.pre_waddr  (pre_waddr),
		.pre_wdata  (pre_wdata)
	);

	kmp_scan #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_scan (
		.clk      (clk),
		.cmd      (scan_cmd),
		.start_j  (scan_start),
		.sym      (scan_sym),
		.pat_rdata(pat_rdata),
		.pre_rdata(pre_rdata),
		.pat_raddr(pat_raddr),
		.pre_raddr(pre_raddr),
		.sts      (scan_sts),
		.result   (scan_result)
	);

	kmp_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pattern_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(pat_waddr),
		.wdata(pat_wdata),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	kmp_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_PATTERN)
	) u_prefix_ram (
		.clk  (clk),
		.we   (pre_we),
		.waddr(pre_waddr),
		.wdata(pre_wdata),
		.raddr(pre_raddr),
		.rdata(pre_rdata)
	);

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready && req.func == FUNC_FINISH))
		else $error("response raised without a finish request");

	a_pat_write_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		pat_we |-> (req_valid && req_ready && req.func == FUNC_PATTERN))
		else $error("pattern memory written outside a pattern request");

	a_scan_load_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cmd.load |-> (req_valid && req_ready && !scan_cmd.fallback))
		else $error("scan unit loaded outside an accepted request");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cmd.load |=> !req_ready)
		else $error("request taken while a byte is in work");

endmodule

// File: dv/kmp_nonoverlap_match_counter_tb.sv
module kmp_nonoverlap_match_counter_tb;
	import kmp_pkg::*;

	localparam int MAX_PAT = MAX_PATTERN_DEF;
	localparam func_t FUNC_UNUSED = func_t'(2'd3);
	localparam int RANDOM_ITEMS = 900;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	kmp_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	kmp_rsp_t rsp;

	always #5 clk = ~clk;

	kmp_nonoverlap_match_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	kmp_req_t    pending[$];
	kmp_rsp_t    count_expect[$];
	int          errors = 0;
	bit          req_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] stall_mask = 16'hFFFF;
	logic [6:0]  stall_tick = '0;

	logic [7:0]  pat_mem[MAX_PAT];
	int          border_tab[MAX_PAT];
	int          pat_len = 0;
	int          border_pos = 0;
	int          scan_pos = 0;
	logic [15:0] hit_total = '0;
	logic        ovf_flag = 1'b0;

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic predict_request(kmp_req_t r);
		int j;
		case (r.func)
			FUNC_PATTERN: begin
				if (r.first) begin
					pat_len = 0;
					border_pos = 0;
					scan_pos = 0;
					ovf_flag = 1'b0;
				end
				if (pat_len >= MAX_PAT) begin
					ovf_flag = 1'b1;
				end else begin
					pat_mem[pat_len] = r.symbol;
					if (pat_len == 0) begin
						border_tab[0] = 0;
						border_pos = 0;
					end else begin
						j = border_pos;
						while (j > 0 && pat_mem[j] != r.symbol)
							j = border_tab[j - 1];
						if (pat_mem[j] == r.symbol)
							j++;
						border_tab[pat_len] = j;
						border_pos = j;
					end
					pat_len++;
				end
			end
			FUNC_TEXT: begin
				if (pat_len != 0) begin
					j = (scan_pos >= pat_len) ? 0 : scan_pos;
					while (j > 0 && pat_mem[j] != r.symbol)
						j = border_tab[j - 1];
					if (pat_mem[j] == r.symbol)
						j++;
					if (j == pat_len) begin
						if (hit_total != COUNT_MAX)
							hit_total++;
						j = 0;
					end
					scan_pos = j;
				end
			end
			FUNC_FINISH: begin
				count_expect.push_back(kmp_rsp_t'{match_count: hit_total,
					pattern_overflow: ovf_flag});
				hit_total = '0;
				scan_pos = 0;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		kmp_rsp_t want;
		req_taken <= req_valid && req_ready;
		if (req_valid && req_ready)
			predict_request(req);
		if (rsp_valid && rsp_ready) begin
			if (count_expect.size() == 0) begin
				report_mismatch("unexpected response, match_count", int'(rsp.match_count), -1);
			end else begin
				want = count_expect.pop_front();
				if (rsp.match_count !== want.match_count)
					report_mismatch("match_count", int'(rsp.match_count),
						int'(want.match_count));
				if (rsp.pattern_overflow !== want.pattern_overflow)
					report_mismatch("pattern_overflow", int'(rsp.pattern_overflow),
						int'(want.pattern_overflow));
			end
		end
	end

	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				req <= pending.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		stall_tick <= stall_tick + 7'd1;
		if (stall_tick == '0)
			stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
		else
			stall_mask <= {stall_mask[0], stall_mask[15:1]};
		rsp_ready <= stall_mask[0];
	end

	task automatic push_req(func_t f, logic [7:0] sym, logic fst);
		pending.push_back(kmp_req_t'{func: f, symbol: sym, first: fst});
	endtask

	function automatic logic [7:0] alpha_sym(int alpha);
		return 8'h61 + 8'($urandom_range(0, alpha - 1));
	endfunction

	task automatic push_pattern(int len, int alpha);
		for (int i = 0; i < len; i++)
			push_req(FUNC_PATTERN, alpha_sym(alpha), i == 0);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending.size() != 0 || req_valid || count_expect.size() != 0);
	endtask

	initial begin
		int issued;
		int kind;
		int plen;
		int tlen;
		int alpha;
		int grow_at;
		int n;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pattern, unused selector, short overlapping pattern, growth, byte extremes
		push_req(FUNC_TEXT, 8'h61, 1'b0);
		push_req(FUNC_TEXT, 8'hFF, 1'b1);
		push_req(FUNC_FINISH, 8'h00, 1'b0);
		push_req(FUNC_UNUSED, 8'hFF, 1'b1);
		push_req(FUNC_PATTERN, 8'h61, 1'b1);
		push_req(FUNC_PATTERN, 8'h62, 1'b0);
		push_req(FUNC_PATTERN, 8'h61, 1'b0);
		for (int i = 0; i < 7; i++)
			push_req(FUNC_TEXT, (i % 2 == 0) ? 8'h61 : 8'h62, 1'b0);
		push_req(FUNC_PATTERN, 8'h63, 1'b0);
		push_req(FUNC_TEXT, 8'h63, 1'b0);
		push_req(FUNC_FINISH, 8'hFF, 1'b1);
		push_req(FUNC_PATTERN, 8'h00, 1'b1);
		push_req(FUNC_PATTERN, 8'hFF, 1'b0);
		push_req(FUNC_TEXT, 8'h00, 1'b1);
		push_req(FUNC_TEXT, 8'hFF, 1'b0);
		push_req(FUNC_TEXT, 8'h00, 1'b0);
		push_req(FUNC_FINISH, 8'h00, 1'b0);
		drain();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) :
					$urandom_range(1, 5);
				alpha = $urandom_range(1, 3);
				tlen = $urandom_range(4, 40);
				grow_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tlen - 1) : -1;
				push_pattern(plen, alpha);
				for (int i = 0; i < tlen; i++) begin
					if (i == grow_at)
						push_req(FUNC_PATTERN, alpha_sym(alpha), 1'b0);
					push_req(FUNC_TEXT, alpha_sym(alpha), 1'b0);
				end
				push_req(FUNC_FINISH, 8'($urandom), 1'($urandom));
				issued += plen + tlen + 2;
			end else if (kind == 7) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_req(func_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
				issued += n;
			end else if (kind == 8) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_req(($urandom_range(0, 1) == 0) ? FUNC_PATTERN : FUNC_TEXT,
						($urandom_range(0, 1) == 0) ? alpha_sym(3) : 8'($urandom), 1'b0);
				if ($urandom_range(0, 1) == 0)
					push_req(FUNC_FINISH, 8'($urandom), 1'($urandom));
				issued += n;
			end else begin
				drain();
			end
		end
		push_req(FUNC_FINISH, 8'h00, 1'b0);
		drain();
		repeat (50) @(posedge clk);

		if (errors == 0)
			$display("kmp_nonoverlap_match_counter verification clean");
		else
			$display("kmp_nonoverlap_match_counter verification failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("kmp_nonoverlap_match_counter verification failed");
		$finish;
	end

endmodule

// File: kmp_nonoverlap_match_counter.f
src/kmp_pkg.sv
src/kmp_ram.sv
src/kmp_scan.sv
src/kmp_seq.sv
src/kmp_nonoverlap_match_counter.sv
dv/kmp_nonoverlap_match_counter_tb.sv
